// File: design/cnf3_pkg.sv
package cnf3_pkg;

	// literal and field widths fixed by the item format
	localparam int LIT_W   = 8;
	localparam int ASG_W   = 64;
	localparam int TOTAL_W = 9;

	// mode codes
	localparam logic [1:0] MODE_SET    = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_CHECK  = 2'd2;

	typedef struct packed {
		logic [1:0]              mode;
		logic [7:0]              clause_index;
		logic signed [LIT_W-1:0] lit_a;
		logic signed [LIT_W-1:0] lit_b;
		logic signed [LIT_W-1:0] lit_c;
		logic [ASG_W-1:0]        assignment;
	} cnf3_in_t;

	typedef struct packed {
		logic               satisfied;
		logic               error;
		logic [TOTAL_W-1:0] clause_total;
	} cnf3_out_t;

	// one stored clause
	typedef struct packed {
		logic [LIT_W-1:0] lit_a;
		logic [LIT_W-1:0] lit_b;
		logic [LIT_W-1:0] lit_c;
	} clause_t;

endpackage

// File: design/cnf3_if.sv
interface cnf3_in_if import cnf3_pkg::*;;
	logic     valid;
	logic     ready;
	cnf3_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cnf3_out_if import cnf3_pkg::*;;
	logic      valid;
	logic      ready;
	cnf3_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/cnf3_clause_checker.sv
// CNF clause store and assignment checker.
// Input channel in_ch carries one beat per command: set a clause at an index,
// append a clause, or check a 64-bit variable assignment against all stored
// clauses. Output channel out_ch returns exactly one beat per command with
// satisfied, error and the clause count after the command.
// Set and append finish in the accept cycle; their result is visible on
// out_ch the next cycle. A check reads the clause memory one entry per cycle
// through its single read port and stops at the first false clause or after
// the last stored clause, reading at most clause count entries (up to
// MAX_CLAUSES); with an empty store it returns its result like a set.
// One command is in flight at a time; in_ch is ready only while no check is
// running and the output register is empty or being taken this cycle.
// When out_ch stalls, the result holds in the output register and in_ch
// stays not ready until it is taken.
// Reset empties the store by clearing the clause count; entries at or above
// the count are never read, so no clearing pass is needed.
module cnf3_clause_checker import cnf3_pkg::*; #(
	parameter int MAX_CLAUSES   = 256,
	parameter int NUM_VARIABLES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	cnf3_in_if.sink     in_ch,
	cnf3_out_if.source  out_ch
);

	localparam int CW = $clog2(MAX_CLAUSES + 1);
	localparam int AW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
	localparam int XW = 16;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic            st_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   ptr_q;
	logic [ASG_W-1:0] asg_q;
	logic            rd_vld_s1;
	logic            rd_last_s1;
	logic            out_vld_q;
	cnf3_out_t       out_q;

	logic            accept;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	clause_t         ram_wdata;
	clause_t         ram_rdata;
	logic            issue;
	logic            clause_false;
	logic            finish;
	logic            res_load;
	cnf3_out_t       res_d;
	logic [CW-1:0]   count_d;
	logic [XW-1:0]   idx_x;
	logic [XW-1:0]   count_x;
	logic [XW-1:0]   count_d_x;

	// literal value under an assignment; zero or out-of-range magnitude is false
	function automatic logic lit_true(logic [LIT_W-1:0] raw, logic [ASG_W-1:0] asg);
		logic [LIT_W-1:0] mag;
		logic [LIT_W-1:0] pos;
		logic             b;
		mag = raw[LIT_W-1] ? (LIT_W'(0) - raw) : raw;
		pos = mag - LIT_W'(1);
		b   = asg[pos[5:0]];
		if (mag == '0 || mag > LIT_W'(NUM_VARIABLES)) begin
			return 1'b0;
		end
		return raw[LIT_W-1] ? !b : b;
	endfunction

	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (st_q == ST_IDLE) && (!out_vld_q || out_ch.ready);

	assign idx_x   = XW'(in_ch.data.clause_index);
	assign count_x = XW'(count_q);

	// command decode for writes and count update
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_x[AW-1:0];
		ram_wdata = '{lit_a: in_ch.data.lit_a, lit_b: in_ch.data.lit_b,
			lit_c: in_ch.data.lit_c};
		count_d   = count_q;
		res_d     = '{satisfied: 1'b0, error: 1'b0, clause_total: '0};
		if (accept) begin
			unique case (in_ch.data.mode)
				MODE_SET: begin
					if (idx_x < count_x) begin
						ram_we = 1'b1;
					end else begin
						res_d.error = 1'b1;
					end
				end
				MODE_APPEND: begin
					if (count_q != CW'(MAX_CLAUSES)) begin
						ram_we    = 1'b1;
						ram_waddr = count_q[AW-1:0];
						count_d   = count_q + CW'(1);
					end else begin
						res_d.error = 1'b1;
					end
				end
				MODE_CHECK: begin
					res_d.satisfied = (count_q == '0);
				end
				default: ;
			endcase
		end else if (finish) begin
			res_d.satisfied = !clause_false;
		end
		count_d_x          = XW'(count_d);
		res_d.clause_total = count_d_x[TOTAL_W-1:0];
	end

	// result goes to the output register unless a check starts a scan
	assign res_load = (accept && !(in_ch.data.mode == MODE_CHECK && count_q != '0)) ||
		finish;

	// scan: one read per cycle, evaluate the clause in the cycle after its read
	assign issue        = (st_q == ST_RUN) && (ptr_q < count_q);
	assign clause_false = !lit_true(ram_rdata.lit_a, asg_q) &&
		!lit_true(ram_rdata.lit_b, asg_q) && !lit_true(ram_rdata.lit_c, asg_q);
	assign finish       = rd_vld_s1 && (clause_false || rd_last_s1);

	cnf3_ram #(
		.WIDTH ($bits(clause_t)),
		.DEPTH (MAX_CLAUSES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			count_q    <= '0;
			ptr_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept && in_ch.data.mode == MODE_CHECK && count_q != '0) begin
				st_q  <= ST_RUN;
				ptr_q <= '0;
			end else if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (finish) begin
				st_q      <= ST_IDLE;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
			end
			rd_last_s1 <= (ptr_q == count_q - CW'(1));
			if (res_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			asg_q <= in_ch.data.assignment;
		end
		if (res_load) begin
			out_q <= res_d;
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.data  = out_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_CLAUSES))
		else $error("clause count above capacity");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> st_q == ST_IDLE)
		else $error("store written during a check");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> st_q == ST_RUN)
		else $error("clause read data valid outside a check");

	a_finish_frees: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> st_q == ST_IDLE && out_vld_q && !rd_vld_s1)
		else $error("check end did not post a result");

endmodule

// File: design/cnf3_ram.sv
module cnf3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sim/tb_cnf3_clause_checker.sv
module tb_cnf3_clause_checker import cnf3_pkg::*;;

	localparam int         MAX_CLAUSES  = 256;
	localparam int         VAR_COUNT    = 64;
	localparam logic [1:0] MODE_IDLE    = 2'd3;   // unused code, changes nothing
	localparam int         RANDOM_ITEMS = 1250;
	// allow for a full-store check and for stalls on both sides
	localparam int         STALL_LIMIT  = 4000;
	localparam int         TAIL_CYCLES  = 300;

	typedef struct {
		cnf3_in_t  item;
		bit        typed;
		cnf3_out_t result;
	} dir_row_t;

	logic clk;
	logic arst_n;

	cnf3_in_if  in_ch ();
	cnf3_out_if out_ch ();

	cnf3_clause_checker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// shadow copy of the clause store
	clause_t     shadow_store [MAX_CLAUSES];
	int          shadow_count = 0;
	cnf3_out_t   pending_q [$];
	dir_row_t    dir_rows [$];
	int          fail_count  = 0;
	int          idle_cycles = 0;
	logic [63:0] plant;        // hidden assignment that most random clauses satisfy
	int          burst_left  = 0;
	bit          pacing      = 1'b1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// literal value: sign negates, zero and magnitudes past the variable count are false
	function automatic bit literal_holds(logic [7:0] raw, logic [63:0] asg);
		int mag;
		mag = raw[7] ? 256 - int'(raw) : int'(raw);
		if (mag == 0 || mag > VAR_COUNT)
			return 1'b0;
		return raw[7] ? !asg[mag-1] : asg[mag-1];
	endfunction

	function automatic bit clause_holds(clause_t c, logic [63:0] asg);
		return literal_holds(c.lit_a, asg) || literal_holds(c.lit_b, asg)
			|| literal_holds(c.lit_c, asg);
	endfunction

	// apply one accepted command to the shadow store and return its result
	function automatic cnf3_out_t apply_command(cnf3_in_t it);
		cnf3_out_t r;
		clause_t   c;
		r = '0;
		c = {it.lit_a, it.lit_b, it.lit_c};
		case (it.mode)
		MODE_SET: begin
			if (int'(it.clause_index) < shadow_count)
				shadow_store[it.clause_index] = c;
			else
				r.error = 1'b1;
		end
		MODE_APPEND: begin
			if (shadow_count < MAX_CLAUSES) begin
				shadow_store[shadow_count] = c;
				shadow_count++;
			end else begin
				r.error = 1'b1;
			end
		end
		MODE_CHECK: begin
			r.satisfied = 1'b1;
			for (int i = 0; i < shadow_count; i++) begin
				if (!clause_holds(shadow_store[i], it.assignment)) begin
					r.satisfied = 1'b0;
					break;
				end
			end
		end
		default: ;
		endcase
		r.clause_total = TOTAL_W'(shadow_count);
		return r;
	endfunction

	function automatic logic [7:0] random_literal();
		case ($urandom_range(0, 9))
		0: return 8'd0;
		1: return 8'($urandom);
		default: return 8'($urandom_range(0, 128) - 64);
		endcase
	endfunction

	// random clause, patched so the hidden assignment makes it true
	function automatic clause_t plant_clause();
		clause_t    c;
		int         v;
		logic [7:0] lit;
		c = {random_literal(), random_literal(), random_literal()};
		if (!clause_holds(c, plant)) begin
			v = $urandom_range(1, VAR_COUNT);
			lit = plant[v-1] ? 8'(v) : 8'(-v);
			case ($urandom_range(0, 2))
			0: c.lit_a = lit;
			1: c.lit_b = lit;
			default: c.lit_c = lit;
			endcase
		end
		return c;
	endfunction

	// lowest stored clause that the hidden assignment leaves false, or -1
	function automatic int first_broken();
		for (int i = 0; i < shadow_count; i++)
			if (!clause_holds(shadow_store[i], plant))
				return i;
		return -1;
	endfunction

	// random command: mostly appends, in-range sets and checks near the hidden assignment
	function automatic cnf3_in_t random_command(int remaining);
		cnf3_in_t it;
		clause_t  c;
		int       pick;
		int       fb;
		it.mode         = MODE_IDLE;
		it.clause_index = 8'($urandom);
		it.lit_a        = 8'($urandom);
		it.lit_b        = 8'($urandom);
		it.lit_c        = 8'($urandom);
		it.assignment   = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0)
			c = {random_literal(), random_literal(), random_literal()};
		else
			c = plant_clause();
		pick = $urandom_range(0, 99);
		// make sure the store fills up before the stimulus runs out
		if (shadow_count < MAX_CLAUSES && remaining <= MAX_CLAUSES - shadow_count + 20)
			pick = 0;
		if (pick < 40) begin
			it.mode = MODE_APPEND;
			{it.lit_a, it.lit_b, it.lit_c} = c;
		end else if (pick < 62 && shadow_count > 0) begin
			it.mode = MODE_SET;
			fb = first_broken();
			if (fb >= 0 && $urandom_range(0, 1) == 1)
				it.clause_index = 8'(fb);
			else
				it.clause_index = 8'($urandom_range(0, shadow_count - 1));
			{it.lit_a, it.lit_b, it.lit_c} = c;
		end else if (pick < 92) begin
			it.mode = MODE_CHECK;
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: it.assignment = plant;
			5, 6: it.assignment = plant ^ (64'd1 << $urandom_range(0, 63))
				^ (64'd1 << $urandom_range(0, 63));
			7: it.assignment = $urandom_range(0, 1) ? '1 : '0;
			default: ;
			endcase
		end else if (pick < 96) begin
			it.mode = MODE_SET;
			if (shadow_count < MAX_CLAUSES)
				it.clause_index = 8'($urandom_range(shadow_count, MAX_CLAUSES - 1));
		end
		return it;
	endfunction

	function automatic void add_row(logic [1:0] mode, int idx, int a, int b, int c,
		logic [63:0] asg, bit typed, bit sat, bit err, int total);
		dir_row_t row;
		row.item.mode          = mode;
		row.item.clause_index  = 8'(idx);
		row.item.lit_a         = 8'(a);
		row.item.lit_b         = 8'(b);
		row.item.lit_c         = 8'(c);
		row.item.assignment    = asg;
		row.typed              = typed;
		row.result.satisfied   = sat;
		row.result.error       = err;
		row.result.clause_total = TOTAL_W'(total);
		dir_rows.push_back(row);
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= 50)
			$display("%0t mismatch: %s", $time, what);
	endtask

	// drive one command beat in bursts with random gaps, record its result on accept
	task automatic send_beat(input cnf3_in_t it, input bit typed, input cnf3_out_t typed_result);
		cnf3_out_t predicted;
		int        gap;
		if (pacing && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 10);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predicted = apply_command(it);
		pending_q.push_back(typed ? typed_result : predicted);
	endtask

	// hold off the sender until every outstanding result has come back
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	// result beats against the oldest outstanding expectation
	always @(posedge clk) begin
		cnf3_out_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("result beat with none outstanding: %p", out_ch.data));
			end else begin
				want = pending_q.pop_front();
				if (out_ch.data.satisfied !== want.satisfied)
					report_mismatch($sformatf("satisfied got %b want %b",
						out_ch.data.satisfied, want.satisfied));
				if (out_ch.data.error !== want.error)
					report_mismatch($sformatf("error got %b want %b",
						out_ch.data.error, want.error));
				if (out_ch.data.clause_total !== want.clause_total)
					report_mismatch($sformatf("clause_total got %0d want %0d",
						out_ch.data.clause_total, want.clause_total));
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				|| (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// result-side backpressure: always ready, random, mostly stalled, or periodic
	initial begin
		int pat;
		int left;
		int cyc;
		int period;
		pat = 0;
		left = 0;
		cyc = 0;
		period = 4;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (left == 0) begin
				pat = $urandom_range(0, 3);
				left = $urandom_range(20, 300);
				period = $urandom_range(2, 9);
			end
			left--;
			cyc++;
			case (pat)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= 1'($urandom_range(0, 1));
			2: out_ch.ready <= ($urandom_range(0, 4) == 0);
			default: out_ch.ready <= ((cyc % period) < (period + 1) / 2);
			endcase
		end
	end

	initial begin
		arst_n      <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data  <= '0;
		plant = {$urandom, $urandom};

		// empty store, out-of-range sets, unused mode, odd literals, first-false stop
		add_row(MODE_CHECK,  0,    0,    0,    0, 64'd0,                  1, 1, 0, 0);
		add_row(MODE_SET,    0,    5,    6,    7, 64'd0,                  1, 0, 1, 0);
		add_row(MODE_IDLE,   255, -128, 127,  -1, '1,                     1, 0, 0, 0);
		add_row(MODE_APPEND, 0,    1,    2,    3, 64'd0,                  1, 0, 0, 1);
		add_row(MODE_APPEND, 0,    0,    0,    0, 64'd0,                  1, 0, 0, 2);
		add_row(MODE_CHECK,  0,    0,    0,    0, '1,                     1, 0, 0, 2);
		add_row(MODE_SET,    1,   -128, 127,  65, 64'd0,                  1, 0, 0, 2);
		add_row(MODE_CHECK,  0,    0,    0,    0, '1,                     1, 0, 0, 2);
		add_row(MODE_SET,    1,    64,  -64,   0, 64'd0,                  1, 0, 0, 2);
		add_row(MODE_CHECK,  0,    0,    0,    0, 64'h8000_0000_0000_0000, 0, 0, 0, 0);
		add_row(MODE_CHECK,  0,    0,    0,    0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0, 0);
		add_row(MODE_SET,    2,    1,    1,    1, 64'd0,                  1, 0, 1, 2);
		add_row(MODE_SET,    255,  1,    1,    1, 64'd0,                  1, 0, 1, 2);
		add_row(MODE_APPEND, 0,   -1,   -2,   -3, 64'd0,                  1, 0, 0, 3);
		add_row(MODE_CHECK,  0,    0,    0,    0, 64'h7,                  0, 0, 0, 0);
		add_row(MODE_CHECK,  0,    0,    0,    0, 64'h6,                  0, 0, 0, 0);
		add_row(MODE_APPEND, 0,   -65,  66, -127, 64'd0,                  0, 0, 0, 0);
		add_row(MODE_CHECK,  0,    0,    0,    0, '1,                     0, 0, 0, 0);
		add_row(MODE_SET,    3,   -64,  64, -128, 64'd0,                  0, 0, 0, 0);
		add_row(MODE_CHECK,  0,    0,    0,    0, '1,                     0, 0, 0, 0);
		add_row(MODE_SET,    2,    1,   -1,    0, 64'd0,                  0, 0, 0, 0);
		add_row(MODE_CHECK,  0,    0,    0,    0, 64'd0,                  0, 0, 0, 0);
		add_row(MODE_CHECK,  0,    0,    0,    0, 64'h1,                  0, 0, 0, 0);
		add_row(MODE_IDLE,   0,    0,    0,    0, 64'd0,                  0, 0, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
		drain_results();

		// random part, with stretches where the sender never idles
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pacing = ((n / 150) % 3) != 1;
			if (n == RANDOM_ITEMS / 2)
				drain_results();
			send_beat(random_command(RANDOM_ITEMS - n), 1'b0, '0);
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
